// ===== rtl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants and the birth and survival rule of the Life generation
// stencil: register indexes, operation codes and field widths.
// ----------------------------------------------------------------------------
package lgs_pkg;

   localparam int MAX_COLS_DEFAULT = 640;
   localparam int MAX_ROWS_DEFAULT = 480;

   localparam int COLS_W    = 10;
   localparam int ROWS_W    = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 10;
   localparam int CNT_W     = 4;
   localparam int CMP_W     = 14;

   localparam int COLS_RESET_VALUE = 640;
   localparam int ROWS_RESET_VALUE = 480;

   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 2'd1;

   localparam logic OP_CELL  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [CNT_W-1:0] SURVIVE_LOW  = 4'd2;
   localparam logic [CNT_W-1:0] BIRTH_COUNT  = 4'd3;

   // B3/S23: a live cell stays with two or three neighbours, a dead one
   // comes alive with exactly three.
   function automatic logic life_rule(input logic centre, input logic [CNT_W-1:0] count);
      logic result;
      if (centre) begin
         result = (count == SURVIVE_LOW) || (count == BIRTH_COUNT);
      end else begin
         result = (count == BIRTH_COUNT);
      end
      return result;
   endfunction

endpackage

// ===== rtl/lgs_if.sv =====
// ----------------------------------------------------------------------------
// Life stencil channels
// Valid/ready channels for cell requests, results and register writes.
// ----------------------------------------------------------------------------
interface lgs_req_if import lgs_pkg::*; ();
   logic valid;
   logic ready;
   logic operation;
   logic cell_alive;

   modport source (output valid, output operation, output cell_alive, input ready);
   modport sink   (input valid, input operation, input cell_alive, output ready);
endinterface

interface lgs_rsp_if import lgs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              next_alive;
   logic [ROWS_W-1:0] row_index;
   logic [COLS_W-1:0] col_index;
   logic              frame_end;

   modport source (output valid, output next_alive, output row_index, output col_index,
                   output frame_end, input ready);
   modport sink   (input valid, input next_alive, input row_index, input col_index,
                   input frame_end, output ready);
endinterface

interface lgs_csr_if import lgs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/lgs_ram.sv =====
// ----------------------------------------------------------------------------
// lgs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lgs_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 640
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/life_generation_stencil.sv =====
// ----------------------------------------------------------------------------
// life_generation_stencil
// One generation of the B3/S23 Life automaton over a raster-ordered grid,
// using a two-row line store and a 3x3 neighbourhood window.
//
//   Channel   Direction  Contents
//   req_chan  in         operation (cell or drain), cell_alive
//   rsp_chan  out        next_alive, row_index, col_index, frame_end
//   csr_chan  in         index (0 cols_in_use, 1 rows_in_use), wdata
//
// One request per clock is sustained while results are taken; a request is
// registered in the working stage, with the registered line-store read, and
// its result in the result register. Results trail the cells by one row plus
// one cell, so a frame needs cols_in_use + 1 drain requests. Reset is
// synchronous and needs no clearing pass: unwritten line-store entries only
// reach window rows that the edge masking hides. A stalled result holds the
// working stage; requests stop only then.
// ----------------------------------------------------------------------------
module life_generation_stencil
   import lgs_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   lgs_req_if.sink   req_chan,
   lgs_rsp_if.source rsp_chan,
   lgs_csr_if.sink   csr_chan
);

   localparam int CI_W = $clog2(MAX_COLS);
   localparam int IR_W = $clog2(MAX_ROWS + 2);
   localparam int OR_W = $clog2(MAX_ROWS);

   localparam int COLS_RST_INT = (COLS_RESET_VALUE > MAX_COLS) ? MAX_COLS : COLS_RESET_VALUE;
   localparam int ROWS_RST_INT = (ROWS_RESET_VALUE > MAX_ROWS) ? MAX_ROWS : ROWS_RESET_VALUE;
   localparam logic [COLS_W-1:0] COLS_RST = COLS_W'(COLS_RST_INT);
   localparam logic [ROWS_W-1:0] ROWS_RST = ROWS_W'(ROWS_RST_INT);

   typedef struct packed {
      logic            alive;
      logic [CI_W-1:0] col;
      logic            emit;
      logic            last;
      logic            left_ok;
      logic            right_ok;
      logic            top_ok;
      logic            bot_ok;
      logic [OR_W-1:0] out_row;
      logic [CI_W-1:0] out_col;
   } stage_type;

   logic [COLS_W-1:0] cols_ff, cols_in;
   logic [ROWS_W-1:0] rows_ff, rows_in;
   logic [CI_W-1:0]   in_col_ff, in_col_in;
   logic [IR_W-1:0]   in_row_ff, in_row_in;
   logic [CI_W-1:0]   out_col_ff, out_col_in;
   logic [OR_W-1:0]   out_row_ff, out_row_in;
   logic              s1_valid_ff, s1_valid_in;
   stage_type         s1_ff, s1_in;
   logic [8:0]        window_ff, window_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              next_alive_ff, next_alive_in;
   logic [ROWS_W-1:0] row_index_ff, row_index_in;
   logic [COLS_W-1:0] col_index_ff, col_index_in;
   logic              frame_end_ff, frame_end_in;

   logic              csr_wr;
   logic              csr_restart;
   logic              req_acc;
   logic              drain;
   logic              cells_done;
   logic              req_eff;
   logic              emit;
   logic              last;
   logic              in_wrap;
   logic              out_wrap;
   logic [CMP_W-1:0]  cols_cmp;
   logic [CMP_W-1:0]  rows_cmp;
   logic [CMP_W-1:0]  in_col_inc;
   logic [CMP_W-1:0]  out_col_inc;
   logic [CMP_W-1:0]  out_row_inc;
   logic              s1_adv;
   logic [1:0]        stored;
   logic [2:0]        newcol;
   logic [7:0]        neighbours;
   logic [CNT_W-1:0]  count;

   // Register writes; columns are clamped to the supported grid size, rows to it after dropping the top bit of wdata.
   assign csr_chan.ready = 1'b1;
   assign csr_wr         = csr_chan.valid && csr_chan.ready;
   assign csr_restart    = csr_wr && ((csr_chan.index == CSR_COLS_IN_USE) ||
                                      (csr_chan.index == CSR_ROWS_IN_USE));

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_wr) begin
         case (csr_chan.index)
            CSR_COLS_IN_USE: begin
               if (CMP_W'(csr_chan.wdata) < CMP_W'(2)) begin
                  cols_in = COLS_W'(2);
               end else if (CMP_W'(csr_chan.wdata) > CMP_W'(MAX_COLS)) begin
                  cols_in = COLS_W'(MAX_COLS);
               end else begin
                  cols_in = csr_chan.wdata[COLS_W-1:0];
               end
            end
            CSR_ROWS_IN_USE: begin
               if (CMP_W'(csr_chan.wdata[ROWS_W-1:0]) < CMP_W'(2)) begin
                  rows_in = ROWS_W'(2);
               end else if (CMP_W'(csr_chan.wdata[ROWS_W-1:0]) > CMP_W'(MAX_ROWS)) begin
                  rows_in = ROWS_W'(MAX_ROWS);
               end else begin
                  rows_in = csr_chan.wdata[ROWS_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Request side: position counters and the decision for each request.
   assign cols_cmp    = CMP_W'(cols_ff);
   assign rows_cmp    = CMP_W'(rows_ff);
   assign in_col_inc  = CMP_W'(in_col_ff) + CMP_W'(1);
   assign out_col_inc = CMP_W'(out_col_ff) + CMP_W'(1);
   assign out_row_inc = CMP_W'(out_row_ff) + CMP_W'(1);

   assign req_acc    = req_chan.valid && req_chan.ready;
   assign drain      = (req_chan.operation == OP_DRAIN);
   assign cells_done = CMP_W'(in_row_ff) >= rows_cmp;
   assign req_eff    = req_acc && (drain == cells_done);
   assign emit       = (CMP_W'(in_row_ff) >= CMP_W'(2)) ||
                       ((in_row_ff == IR_W'(1)) && (in_col_ff != '0));
   assign in_wrap    = in_col_inc >= cols_cmp;
   assign out_wrap   = out_col_inc >= cols_cmp;
   assign last       = (out_row_inc >= rows_cmp) && out_wrap;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (req_eff) begin
         if (in_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + IR_W'(1);
         end else begin
            in_col_in = CI_W'(in_col_inc);
         end
         if (emit) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_wrap) begin
               out_col_in = '0;
               out_row_in = OR_W'(out_row_inc);
            end else begin
               out_col_in = CI_W'(out_col_inc);
            end
         end
      end
   end

   // Working stage: line-store data arrives, window shifts, rule is applied.
   assign s1_adv         = s1_valid_ff && (!s1_ff.emit || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;

   always_comb begin
      s1_in          = s1_ff;
      s1_valid_in    = s1_valid_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (req_eff) begin
         s1_valid_in    = 1'b1;
         s1_in.alive    = drain ? 1'b0 : req_chan.cell_alive;
         s1_in.col      = in_col_ff;
         s1_in.emit     = emit;
         s1_in.last     = last;
         s1_in.left_ok  = (out_col_ff != '0);
         s1_in.right_ok = !out_wrap;
         s1_in.top_ok   = (out_row_ff != '0);
         s1_in.bot_ok   = (out_row_inc < rows_cmp);
         s1_in.out_row  = out_row_ff;
         s1_in.out_col  = out_col_ff;
      end
   end

   lgs_ram #(
      .WIDTH (2),
      .DEPTH (MAX_COLS)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_ff.col),
      .wr_data ({stored[0], s1_ff.alive}),
      .rd_en   (req_acc),
      .rd_addr (in_col_ff),
      .rd_data (stored)
   );

   // Window bit 3*column + row; the new column enters on the right.
   assign newcol    = {s1_ff.alive, stored[0], stored[1]};
   assign window_in = s1_adv ? {newcol, window_ff[8:3]} : window_ff;

   always_comb begin
      neighbours[0] = window_in[0] && s1_ff.left_ok && s1_ff.top_ok;
      neighbours[1] = window_in[1] && s1_ff.left_ok;
      neighbours[2] = window_in[2] && s1_ff.left_ok && s1_ff.bot_ok;
      neighbours[3] = window_in[3] && s1_ff.top_ok;
      neighbours[4] = window_in[5] && s1_ff.bot_ok;
      neighbours[5] = window_in[6] && s1_ff.right_ok && s1_ff.top_ok;
      neighbours[6] = window_in[7] && s1_ff.right_ok;
      neighbours[7] = window_in[8] && s1_ff.right_ok && s1_ff.bot_ok;
      count = '0;
      for (int i = 0; i < 8; i++) begin
         count = count + CNT_W'(neighbours[i]);
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      next_alive_in = next_alive_ff;
      row_index_in  = row_index_ff;
      col_index_in  = col_index_ff;
      frame_end_in  = frame_end_ff;
      if (s1_adv && s1_ff.emit) begin
         rsp_valid_in  = 1'b1;
         next_alive_in = life_rule(window_in[4], count);
         row_index_in  = ROWS_W'(s1_ff.out_row);
         col_index_in  = COLS_W'(s1_ff.out_col);
         frame_end_in  = s1_ff.last;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.next_alive = next_alive_ff;
   assign rsp_chan.row_index  = row_index_ff;
   assign rsp_chan.col_index  = col_index_ff;
   assign rsp_chan.frame_end  = frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= COLS_RST;
         rows_ff      <= ROWS_RST;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         window_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         s1_valid_ff  <= s1_valid_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff         <= s1_in;
      next_alive_ff <= next_alive_in;
      row_index_ff  <= row_index_in;
      col_index_ff  <= col_index_in;
      frame_end_ff  <= frame_end_in;
   end

   // The output column never reaches the row width.
   assert property (@(posedge clock) disable iff (reset)
      CMP_W'(out_col_ff) < cols_cmp)
      else $error("output column outside the grid");

   // The input row counter never exceeds rows_in_use + 1.
   assert property (@(posedge clock) disable iff (reset)
      CMP_W'(in_row_ff) <= rows_cmp + CMP_W'(1))
      else $error("input row counter ran past the flush");

   // The last result of a frame restarts every position counter.
   assert property (@(posedge clock) disable iff (reset)
      (req_eff && emit && last && !csr_wr) |=>
         (in_col_ff == '0) && (in_row_ff == '0) && (out_col_ff == '0) && (out_row_ff == '0))
      else $error("frame end did not restart the counters");

   // A frame-end result lies on the last column of the grid.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && frame_end_ff) |->
         (CMP_W'(col_index_ff) + CMP_W'(1) == cols_cmp))
      else $error("frame end away from the last column");

endmodule
